/* rtl/lmi_pkg.sv */
// Shared types, constants and saturating helpers for the 4x4 LU matrix inverse.
// Used by every module of the block; depends on nothing.
package lmi_pkg;

    localparam int DIM        = 4;
    localparam int IDX_BITS   = 2;
    localparam int ADDR_BITS  = 2 * IDX_BITS;
    localparam int IO_BITS    = 32;
    localparam int ROW_BITS   = DIM * IO_BITS;
    localparam int INNER_BITS = 48;
    localparam int FRAC_BITS  = 16;
    localparam int HALF_BITS  = INNER_BITS / 2;
    localparam int PROD_BITS  = 2 * INNER_BITS;
    localparam int NUM_BITS   = INNER_BITS + FRAC_BITS;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS  = 2;

    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(DIM - 1);

    typedef logic signed [INNER_BITS-1:0] inner_t;

    localparam inner_t MAXV = {1'b0, {(INNER_BITS-1){1'b1}}};
    localparam inner_t MINV = {1'b1, {(INNER_BITS-1){1'b0}}};
    localparam inner_t ONE  = inner_t'(1) <<< FRAC_BITS;

    typedef struct packed {
        logic [ROW_BITS-1:0] data;
        logic                last;
    } row_item_t;

    typedef struct packed {
        logic   start;
        inner_t a;
        inner_t b;
    } op_req_t;

    typedef struct packed {
        logic   done;
        inner_t q;
    } op_rsp_t;

    typedef enum logic [2:0] {
        PH_U, PH_L, PH_LI, PH_UD, PH_UI, PH_OUT
    } phase_t;

    typedef enum logic [3:0] {
        ST_LOAD, ST_START, ST_RD, ST_MULGO, ST_MUL, ST_FRD, ST_FIN,
        ST_DIV, ST_WB, ST_EMIT, ST_SEMIT
    } state_t;

    function automatic inner_t sat_add(inner_t a, inner_t b);
        logic [INNER_BITS:0] s;
        s = {a[INNER_BITS-1], a} + {b[INNER_BITS-1], b};
        if (s[INNER_BITS] != s[INNER_BITS-1]) return s[INNER_BITS] ? MINV : MAXV;
        return inner_t'(s[INNER_BITS-1:0]);
    endfunction

    function automatic inner_t sat_sub(inner_t a, inner_t b);
        logic [INNER_BITS:0] s;
        s = {a[INNER_BITS-1], a} - {b[INNER_BITS-1], b};
        if (s[INNER_BITS] != s[INNER_BITS-1]) return s[INNER_BITS] ? MINV : MAXV;
        return inner_t'(s[INNER_BITS-1:0]);
    endfunction

    function automatic inner_t sat_neg(inner_t a);
        if (a == MINV) return MAXV;
        return -a;
    endfunction

    function automatic logic [INNER_BITS-1:0] magn(inner_t a);
        return a[INNER_BITS-1] ? INNER_BITS'(-a) : INNER_BITS'(a);
    endfunction

    function automatic logic [ADDR_BITS-1:0] addr(logic [IDX_BITS-1:0] r,
                                                  logic [IDX_BITS-1:0] c);
        return {r, c};
    endfunction

endpackage

/* rtl/lmi_queue.sv */
// Short row queue between the front and the compute sequencer.
// Depends on lmi_pkg.
module lmi_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  lmi_pkg::row_item_t push_item,
    output logic              full,
    input  logic              pop,
    output lmi_pkg::row_item_t pop_item,
    output logic              empty
);
    import lmi_pkg::*;

    row_item_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_BITS:0]     cnt_reg, cnt_next;

    assign full     = cnt_reg == (QPTR_BITS+1)'(QUEUE_DEPTH);
    assign empty    = cnt_reg == '0;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_BITS'(push);
        rd_ptr_next = rd_ptr_reg + QPTR_BITS'(pop);
        cnt_next    = cnt_reg + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end
endmodule

/* rtl/lmi_front.sv */
// Input side: accepts matrix rows and tags the last row of each matrix.
// Depends on lmi_pkg; feeds lmi_queue.
module lmi_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [lmi_pkg::ROW_BITS-1:0] s_axis_tdata,
    input  logic                         q_full,
    output logic                         q_push,
    output lmi_pkg::row_item_t           q_item
);
    import lmi_pkg::*;

    logic [IDX_BITS-1:0] row_cnt_reg, row_cnt_next;

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    always_comb begin
        q_item.data  = s_axis_tdata;
        q_item.last  = row_cnt_reg == LAST_IDX;
        row_cnt_next = q_push ? row_cnt_reg + IDX_BITS'(1) : row_cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
        end else begin
            row_cnt_reg <= row_cnt_next;
        end
    end
endmodule

/* rtl/lmi_mul.sv */
// Fixed-point multiplier: 48x48 magnitude product from four 24x24 partial
// products, then round to nearest and saturate. Depends on lmi_pkg.
module lmi_mul (
    input  logic             aclk,
    input  logic             aresetn,
    input  lmi_pkg::op_req_t req,
    output lmi_pkg::op_rsp_t rsp
);
    import lmi_pkg::*;

    logic [INNER_BITS-1:0] a_reg, b_reg;
    logic                  neg_reg;
    logic [PROD_BITS-1:0]  acc_reg, acc_next;
    logic [1:0]            cnt_reg;
    logic                  busy_reg, fin_reg;
    inner_t                q_reg, q_next;
    logic                  done_reg;

    logic [HALF_BITS-1:0]   ha, hb;
    logic [INNER_BITS-1:0]  pp;
    logic [PROD_BITS-1:0]   pp_sh;
    logic [PROD_BITS-1:0]   rnd;
    logic [PROD_BITS-1:0]   lim;
    logic [INNER_BITS-1:0]  v;

    always_comb begin
        ha = cnt_reg[0] ? a_reg[INNER_BITS-1:HALF_BITS] : a_reg[HALF_BITS-1:0];
        hb = cnt_reg[1] ? b_reg[INNER_BITS-1:HALF_BITS] : b_reg[HALF_BITS-1:0];
        pp = INNER_BITS'(ha) * INNER_BITS'(hb);
        case (cnt_reg)
            2'd0:    pp_sh = PROD_BITS'(pp);
            2'd3:    pp_sh = PROD_BITS'(pp) << INNER_BITS;
            default: pp_sh = PROD_BITS'(pp) << HALF_BITS;
        endcase
        acc_next = acc_reg + pp_sh;
        rnd = (acc_reg + (PROD_BITS'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        lim = neg_reg ? PROD_BITS'(magn(MINV)) : PROD_BITS'(MAXV);
        v   = (rnd > lim) ? lim[INNER_BITS-1:0] : rnd[INNER_BITS-1:0];
        q_next = neg_reg ? -inner_t'(v) : inner_t'(v);
    end

    assign rsp.done = done_reg;
    assign rsp.q    = q_reg;

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg   <= magn(req.a);
            b_reg   <= magn(req.b);
            neg_reg <= req.a[INNER_BITS-1] != req.b[INNER_BITS-1];
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
        end
        if (fin_reg) begin
            q_reg <= q_next;
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= fin_reg;
            fin_reg  <= busy_reg && cnt_reg == 2'd3;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) busy_reg <= 1'b0;
            end
        end
    end
endmodule

/* rtl/lmi_div.sv */
// Fixed-point divider: (a << FRAC_BITS) / b, restoring, one quotient bit per
// cycle, rounded to nearest and saturated. Depends on lmi_pkg.
module lmi_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  lmi_pkg::op_req_t req,
    output lmi_pkg::op_rsp_t rsp
);
    import lmi_pkg::*;

    localparam int CNT_BITS = $clog2(NUM_BITS) + 1;

    logic [NUM_BITS-1:0]   n_reg, q_reg;
    logic [INNER_BITS-1:0] d_reg;
    logic [INNER_BITS:0]   rem_reg;
    logic                  neg_reg, busy_reg, fin_reg, done_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    inner_t                res_reg, res_next;

    logic [INNER_BITS:0]   rs, rs_sub;
    logic                  ge;
    logic                  rnd;
    logic [NUM_BITS:0]     q1, lim;
    logic [INNER_BITS-1:0] v;

    always_comb begin
        rs     = {rem_reg[INNER_BITS-1:0], n_reg[NUM_BITS-1]};
        rs_sub = rs - {1'b0, d_reg};
        ge     = rs >= {1'b0, d_reg};
        rnd    = rem_reg >= ({1'b0, d_reg} - rem_reg);
        q1     = {1'b0, q_reg} + (NUM_BITS+1)'(rnd);
        lim    = neg_reg ? (NUM_BITS+1)'(magn(MINV)) : (NUM_BITS+1)'(MAXV);
        v      = (q1 > lim) ? lim[INNER_BITS-1:0] : q1[INNER_BITS-1:0];
        res_next = neg_reg ? -inner_t'(v) : inner_t'(v);
    end

    assign rsp.done = done_reg;
    assign rsp.q    = res_reg;

    always_ff @(posedge aclk) begin
        if (req.start) begin
            n_reg   <= {magn(req.a), {FRAC_BITS{1'b0}}};
            d_reg   <= magn(req.b);
            neg_reg <= req.a[INNER_BITS-1] != req.b[INNER_BITS-1];
            rem_reg <= '0;
            q_reg   <= '0;
        end else if (busy_reg) begin
            n_reg   <= n_reg << 1;
            rem_reg <= ge ? rs_sub : rs;
            q_reg   <= {q_reg[NUM_BITS-2:0], ge};
        end
        if (fin_reg) begin
            res_reg <= res_next;
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= fin_reg;
            fin_reg  <= busy_reg && cnt_reg == CNT_BITS'(NUM_BITS - 1);
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(NUM_BITS - 1)) busy_reg <= 1'b0;
            end
        end
    end
endmodule

/* rtl/lmi_back.sv */
// Compute sequencer: loads a matrix from the queue, runs LU, inverts L and U,
// forms inv(U)*inv(L) and drives the result register. Depends on lmi_pkg,
// lmi_mul and lmi_div.
module lmi_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_empty,
    input  lmi_pkg::row_item_t           q_item,
    output logic                         q_pop,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [lmi_pkg::ROW_BITS-1:0] m_axis_tdata,
    output logic [1:0]                   m_axis_tuser,
    output logic                         m_axis_tlast
);
    import lmi_pkg::*;

    logic [ROW_BITS-1:0] a_mem [DIM];
    inner_t              f_mem [DIM*DIM];
    inner_t              li_mem [DIM*DIM];
    inner_t              ui_mem [DIM*DIM];

    logic [ROW_BITS-1:0] a_rd_reg;
    inner_t              fx_rd_reg, fy_rd_reg, li_rd_reg, ux_rd_reg, uy_rd_reg;

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [IDX_BITS-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [IDX_BITS-1:0] load_row_reg, load_row_next;
    inner_t              s_reg, s_next, res_reg, res_next;
    logic [IO_BITS-1:0]  row_reg [DIM];
    logic                clip_reg, clip_next;

    logic                out_valid_reg, out_valid_next;
    logic [ROW_BITS-1:0] out_data_reg;
    logic                out_sing_reg, out_sat_reg, out_last_reg;

    op_req_t mul_req, div_req;
    op_rsp_t mul_rsp, div_rsp;

    logic [IDX_BITS-1:0]  kfirst, klast;
    logic                 kempty;
    logic [ADDR_BITS-1:0] fx_addr, fy_addr, li_addr, ux_addr, uy_addr;
    logic [IDX_BITS-1:0]  a_row, a_col;
    inner_t               a_el, x_op, y_op, fin_val;
    logic                 slot_free, do_emit, fin_clip;
    logic [IO_BITS-1:0]   fin_io;
    logic                 wr_f, wr_li, wr_ui, wr_row;
    logic [ADDR_BITS-1:0] wr_addr;

    lmi_mul u_mul (.aclk(aclk), .aresetn(aresetn), .req(mul_req), .rsp(mul_rsp));
    lmi_div u_div (.aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp));

    assign slot_free = !out_valid_reg || m_axis_tready;

    // loop bounds of the inner sum
    always_comb begin
        kfirst = '0;
        klast  = i_reg - IDX_BITS'(1);
        case (phase_reg)
            PH_UI:   begin kfirst = j_reg + IDX_BITS'(1); klast = i_reg; end
            PH_OUT:  klast = LAST_IDX;
            default: klast = i_reg - IDX_BITS'(1);
        endcase
        kempty = (phase_reg == PH_UD) ||
                 ((phase_reg == PH_U || phase_reg == PH_L || phase_reg == PH_LI) &&
                  i_reg == '0);
    end

    // read addresses
    always_comb begin
        fx_addr = (phase_reg == PH_L || phase_reg == PH_UI) ? addr(j_reg, k_reg)
                                                            : addr(i_reg, k_reg);
        if (state_reg == ST_FRD) begin
            fy_addr = (phase_reg == PH_UI) ? addr(j_reg, j_reg) : addr(i_reg, i_reg);
        end else begin
            fy_addr = (phase_reg == PH_L) ? addr(k_reg, i_reg) : addr(k_reg, j_reg);
        end
        li_addr = addr(k_reg, j_reg);
        ux_addr = addr(i_reg, k_reg);
        uy_addr = addr(k_reg, i_reg);
        a_row   = (phase_reg == PH_L) ? j_reg : i_reg;
        a_col   = (phase_reg == PH_L) ? i_reg : j_reg;
    end

    // operands and finishing values
    always_comb begin
        if (phase_reg == PH_OUT) begin
            x_op = (k_reg < i_reg) ? '0 : ux_rd_reg;
        end else begin
            x_op = fx_rd_reg;
        end
        case (phase_reg)
            PH_U, PH_L: y_op = fy_rd_reg;
            PH_UI:      y_op = uy_rd_reg;
            default: begin
                if (k_reg == j_reg)     y_op = ONE;
                else if (k_reg < j_reg) y_op = '0;
                else                    y_op = li_rd_reg;
            end
        endcase
        a_el = inner_t'(signed'(a_rd_reg[a_col*IO_BITS +: IO_BITS]));
        case (phase_reg)
            PH_U:    fin_val = sat_sub(a_el, s_reg);
            PH_L:    fin_val = sat_sub(a_el, s_reg);
            PH_UD:   fin_val = ONE;
            default: fin_val = sat_neg(s_reg);
        endcase
        fin_clip = (s_reg > inner_t'(MAXV >>> (INNER_BITS - IO_BITS))) ||
                   (s_reg < inner_t'(MINV >>> (INNER_BITS - IO_BITS)));
        if (s_reg > inner_t'(MAXV >>> (INNER_BITS - IO_BITS))) begin
            fin_io = {1'b0, {(IO_BITS-1){1'b1}}};
        end else if (s_reg < inner_t'(MINV >>> (INNER_BITS - IO_BITS))) begin
            fin_io = {1'b1, {(IO_BITS-1){1'b0}}};
        end else begin
            fin_io = s_reg[IO_BITS-1:0];
        end
    end

    // next state and indices
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        load_row_next = load_row_reg;
        s_next        = s_reg;
        res_next      = res_reg;
        clip_next     = clip_reg;
        case (state_reg)
            ST_LOAD: begin
                if (!q_empty) begin
                    load_row_next = load_row_reg + IDX_BITS'(1);
                    if (q_item.last) begin
                        phase_next = PH_U;
                        i_next     = '0;
                        j_next     = '0;
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                s_next = '0;
                k_next = kfirst;
                if (phase_reg == PH_OUT && j_reg == '0) clip_next = 1'b0;
                state_next = kempty ? ST_FRD : ST_RD;
            end
            ST_RD:    state_next = ST_MULGO;
            ST_MULGO: state_next = ST_MUL;
            ST_MUL: begin
                if (mul_rsp.done) begin
                    s_next = sat_add(s_reg, mul_rsp.q);
                    if (k_reg == klast) begin
                        state_next = ST_FRD;
                    end else begin
                        k_next     = k_reg + IDX_BITS'(1);
                        state_next = ST_RD;
                    end
                end
            end
            ST_FRD: state_next = ST_FIN;
            ST_FIN: begin
                case (phase_reg)
                    PH_U, PH_LI: begin
                        res_next   = fin_val;
                        state_next = ST_WB;
                    end
                    PH_OUT: begin
                        clip_next  = clip_reg || fin_clip;
                        state_next = ST_WB;
                    end
                    default: state_next = ST_DIV;
                endcase
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    res_next   = div_rsp.q;
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                state_next = ST_START;
                case (phase_reg)
                    PH_U: begin
                        if (j_reg == i_reg && res_reg == '0) begin
                            i_next     = '0;
                            state_next = ST_SEMIT;
                        end else if (j_reg == LAST_IDX) begin
                            if (i_reg == LAST_IDX) begin
                                phase_next = PH_LI;
                                i_next     = IDX_BITS'(1);
                                j_next     = '0;
                            end else begin
                                phase_next = PH_L;
                                j_next     = i_reg + IDX_BITS'(1);
                            end
                        end else begin
                            j_next = j_reg + IDX_BITS'(1);
                        end
                    end
                    PH_L: begin
                        if (j_reg == LAST_IDX) begin
                            phase_next = PH_U;
                            i_next     = i_reg + IDX_BITS'(1);
                            j_next     = i_reg + IDX_BITS'(1);
                        end else begin
                            j_next = j_reg + IDX_BITS'(1);
                        end
                    end
                    PH_LI: begin
                        if (j_reg == i_reg - IDX_BITS'(1)) begin
                            j_next = '0;
                            if (i_reg == LAST_IDX) begin
                                phase_next = PH_UD;
                                i_next     = '0;
                            end else begin
                                i_next = i_reg + IDX_BITS'(1);
                            end
                        end else begin
                            j_next = j_reg + IDX_BITS'(1);
                        end
                    end
                    PH_UD: begin
                        if (i_reg == LAST_IDX) begin
                            phase_next = PH_UI;
                            i_next     = IDX_BITS'(1);
                            j_next     = '0;
                        end else begin
                            i_next = i_reg + IDX_BITS'(1);
                        end
                    end
                    PH_UI: begin
                        if (j_reg == '0) begin
                            if (i_reg == LAST_IDX) begin
                                phase_next = PH_OUT;
                                i_next     = '0;
                                j_next     = '0;
                            end else begin
                                i_next = i_reg + IDX_BITS'(1);
                                j_next = i_reg;
                            end
                        end else begin
                            j_next = j_reg - IDX_BITS'(1);
                        end
                    end
                    PH_OUT: begin
                        if (j_reg == LAST_IDX) begin
                            state_next = ST_EMIT;
                        end else begin
                            j_next = j_reg + IDX_BITS'(1);
                        end
                    end
                    default: state_next = ST_LOAD;
                endcase
            end
            ST_EMIT, ST_SEMIT: begin
                if (slot_free) begin
                    if (i_reg == LAST_IDX) begin
                        state_next = ST_LOAD;
                    end else begin
                        i_next     = i_reg + IDX_BITS'(1);
                        j_next     = '0;
                        state_next = (state_reg == ST_EMIT) ? ST_START : ST_SEMIT;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        q_pop         = state_reg == ST_LOAD && !q_empty;
        mul_req.start = state_reg == ST_MULGO;
        mul_req.a     = x_op;
        mul_req.b     = y_op;
        div_req.start = state_reg == ST_FIN &&
                        (phase_reg == PH_L || phase_reg == PH_UD || phase_reg == PH_UI);
        div_req.a     = fin_val;
        div_req.b     = fy_rd_reg;
        wr_f          = state_reg == ST_WB && (phase_reg == PH_U || phase_reg == PH_L);
        wr_li         = state_reg == ST_WB && phase_reg == PH_LI;
        wr_ui         = state_reg == ST_WB && (phase_reg == PH_UD || phase_reg == PH_UI);
        wr_row        = state_reg == ST_FIN && phase_reg == PH_OUT;
        case (phase_reg)
            PH_L:    wr_addr = addr(j_reg, i_reg);
            PH_UD:   wr_addr = addr(i_reg, i_reg);
            PH_UI:   wr_addr = addr(j_reg, i_reg);
            default: wr_addr = addr(i_reg, j_reg);
        endcase
        do_emit        = (state_reg == ST_EMIT || state_reg == ST_SEMIT) && slot_free;
        out_valid_next = do_emit || (out_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge aclk) begin
        if (q_pop) a_mem[load_row_reg] <= q_item.data;
        if (wr_f)  f_mem[wr_addr]  <= res_reg;
        if (wr_li) li_mem[wr_addr] <= res_reg;
        if (wr_ui) ui_mem[wr_addr] <= res_reg;
        a_rd_reg  <= a_mem[a_row];
        fx_rd_reg <= f_mem[fx_addr];
        fy_rd_reg <= f_mem[fy_addr];
        li_rd_reg <= li_mem[li_addr];
        ux_rd_reg <= ui_mem[ux_addr];
        uy_rd_reg <= ui_mem[uy_addr];
    end

    always_ff @(posedge aclk) begin
        s_reg   <= s_next;
        res_reg <= res_next;
        k_reg   <= k_next;
        if (wr_row) row_reg[j_reg] <= fin_io;
        if (do_emit) begin
            out_sing_reg <= state_reg == ST_SEMIT;
            out_sat_reg  <= (state_reg == ST_EMIT) && clip_reg;
            out_last_reg <= i_reg == LAST_IDX;
            for (int c = 0; c < DIM; c++) begin
                out_data_reg[c*IO_BITS +: IO_BITS] <=
                    (state_reg == ST_EMIT) ? row_reg[c] : '0;
            end
        end
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            phase_reg     <= PH_U;
            i_reg         <= '0;
            j_reg         <= '0;
            load_row_reg  <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            load_row_reg  <= load_row_next;
            clip_reg      <= clip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = {out_sat_reg, out_sing_reg};
    assign m_axis_tlast  = out_last_reg;
endmodule

/* rtl/lu_matrix_inverse_4x4_unit.sv */
// 4x4 fixed-point matrix inverse by LU factorization: top level.
// Depends on lmi_pkg, lmi_front, lmi_queue and lmi_back.
//
// Send a matrix as four rows of signed Q16.16 elements; after the fourth row
// the block returns the four rows of the inverse, Q16.16 and saturated, with
// tlast on the final row. A zero pivot in U gives four zero rows flagged
// singular. Rows are buffered in a four-entry queue, so the next matrix may
// load while the current one is computed. The compute side runs on a single
// shared multiplier and a bit-serial divider.
module lu_matrix_inverse_4x4_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [lmi_pkg::ROW_BITS-1:0] s_axis_tdata,  // col0, col1, col2, col3
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [lmi_pkg::ROW_BITS-1:0] m_axis_tdata,  // inv0, inv1, inv2, inv3
    output logic [1:0]                   m_axis_tuser,  // singular, saturated
    output logic                         m_axis_tlast   // last_row
);
    import lmi_pkg::*;

    logic      q_full, q_push, q_empty, q_pop;
    row_item_t q_in, q_out;

    lmi_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .q_full(q_full), .q_push(q_push), .q_item(q_in)
    );

    lmi_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_item(q_in), .full(q_full),
        .pop(q_pop), .pop_item(q_out), .empty(q_empty)
    );

    lmi_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_empty(q_empty), .q_item(q_out), .q_pop(q_pop),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );
endmodule
